### hw/rtl/assert_macros.svh
// Assertion helpers included by path_scanline_steering.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pss_pkg.sv
package pss_pkg;

  // Geometry
  localparam int unsigned COL_W = 10;
  localparam logic [10:0] MAX_WIDTH = 11'd1024;
  localparam logic [10:0] MIN_WIDTH = 11'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TURN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_TURN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_MARGIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_MARGIN = 3'd7;

  // Queue depths
  localparam int unsigned DEC_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    ACT_FWD   = 2'd0,
    ACT_LEFT  = 2'd1,
    ACT_RIGHT = 2'd2
  } action_e;

  typedef struct packed {
    logic        pixel_on_path;
    logic        row_sel;
    logic [19:0] area_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] amount;
    logic        give_up;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [19:0] min_area;
    logic [7:0]  lost_limit;
    logic [13:0] move_speed;
    logic [14:0] half_turn;
    logic [14:0] small_turn;
    logic [9:0]  turn_margin;
    logic [9:0]  forward_margin;
  } cfg_t;

  // Derived row geometry
  typedef struct packed {
    logic [COL_W-1:0] last_col;
    logic [COL_W-1:0] centre;
  } geom_t;

  // Frame decision handed from the scanner to the steering stage
  typedef struct packed {
    logic [COL_W-1:0] best_mid;
    logic             lost;
  } dec_t;

endpackage

### hw/rtl/pss_front.sv
module pss_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pss_pkg::cfg_t    cfg_i,
  input  pss_pkg::geom_t   geom_i,
  input  logic             push_i,
  input  pss_pkg::in_item_t item_i,
  input  logic             dq_full_i,
  output logic             full_o,
  output logic             dec_push_o,
  output pss_pkg::dec_t    dec_o
);

  logic [pss_pkg::COL_W-1:0] col_q, run_start_q, best_mid_q;
  logic [pss_pkg::COL_W:0]   best_dist_q;
  logic                      in_run_q, upper_q, lower_q;

  logic                      accept, px, row, row_end, close_run, frame_end, upd_best;
  logic [pss_pkg::COL_W-1:0] start, run_end, mid, mid_dist;
  logic [pss_pkg::COL_W:0]   sum;
  logic                      upper_n, lower_n;
  logic [pss_pkg::COL_W-1:0] best_mid_n;
  logic [pss_pkg::COL_W:0]   best_dist_n;

  assign full_o = dq_full_i;
  assign accept = push_i & ~dq_full_i;
  assign px     = item_i.pixel_on_path;
  assign row    = item_i.row_sel;

  // Track the current run and its midpoint
  assign row_end   = (col_q >= geom_i.last_col);
  assign close_run = px ? row_end : in_run_q;
  assign start     = (px & ~in_run_q) ? col_q : run_start_q;
  assign run_end   = px ? col_q : (col_q - pss_pkg::COL_W'(1));
  assign sum       = {1'b0, start} + {1'b0, run_end};
  assign mid       = sum[pss_pkg::COL_W:1];
  assign mid_dist  = (mid >= geom_i.centre) ? (mid - geom_i.centre) : (geom_i.centre - mid);

  // Keep the upper-row midpoint closest to the centre, first one wins ties
  assign upd_best    = close_run & ~row & ({1'b0, mid_dist} < best_dist_q);
  assign upper_n     = upper_q | (close_run & ~row);
  assign lower_n     = lower_q | (close_run & row);
  assign best_mid_n  = upd_best ? mid : best_mid_q;
  assign best_dist_n = upd_best ? {1'b0, mid_dist} : best_dist_q;

  // Classify the frame on its last lower-row pixel
  assign frame_end       = row_end & row;
  assign dec_push_o      = accept & frame_end;
  assign dec_o.best_mid  = best_mid_n;
  assign dec_o.lost      = (item_i.area_size < cfg_i.min_area) | ~upper_n | ~lower_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      in_run_q    <= 1'b0;
      run_start_q <= '0;
      best_mid_q  <= '0;
      best_dist_q <= '1;
      upper_q     <= 1'b0;
      lower_q     <= 1'b0;
    end else if (accept) begin
      col_q    <= row_end ? '0 : (col_q + pss_pkg::COL_W'(1));
      in_run_q <= (row_end | close_run) ? 1'b0 : (px | in_run_q);
      if (frame_end) begin
        run_start_q <= '0;
        best_mid_q  <= '0;
        best_dist_q <= '1;
        upper_q     <= 1'b0;
        lower_q     <= 1'b0;
      end else begin
        run_start_q <= start;
        best_mid_q  <= best_mid_n;
        best_dist_q <= best_dist_n;
        upper_q     <= upper_n;
        lower_q     <= lower_n;
      end
    end
  end

endmodule

### hw/rtl/pss_dec_fifo.sv
module pss_dec_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pss_pkg::dec_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pss_pkg::dec_t data_o
);

  localparam int unsigned PtrW = $clog2(pss_pkg::DEC_DEPTH);
  localparam int unsigned CntW = $clog2(pss_pkg::DEC_DEPTH + 1);

  pss_pkg::dec_t     mem_q [pss_pkg::DEC_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(pss_pkg::DEC_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  // Store decision payload
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

### hw/rtl/pss_back.sv
module pss_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pss_pkg::cfg_t      cfg_i,
  input  pss_pkg::geom_t     geom_i,
  input  logic               dec_empty_i,
  input  pss_pkg::dec_t      dec_i,
  output logic               dec_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output pss_pkg::res_item_t res_o
);

  localparam int unsigned PtrW = $clog2(pss_pkg::OUT_DEPTH);
  localparam int unsigned CntW = $clog2(pss_pkg::OUT_DEPTH + 1);

  pss_pkg::res_item_t mem_q [pss_pkg::OUT_DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic [7:0]         lost_count_q;
  logic [1:0]         prev_action_q;

  logic                      take, do_pop, give_up, neg, turn, fwd, two;
  logic [7:0]                lc_inc;
  logic [pss_pkg::COL_W:0]   diff;
  logic [pss_pkg::COL_W-1:0] mag;
  logic [1:0]                rot_act, opp_act;
  pss_pkg::res_item_t        r0, r1;
  logic [1:0]                n_res;

  // Take a decision only when two result slots are free
  assign take      = ~dec_empty_i & (count_q <= CntW'(pss_pkg::OUT_DEPTH - 2));
  assign dec_pop_o = take;

  // Lost path bookkeeping
  assign lc_inc  = lost_count_q + 8'd1;
  assign give_up = (lc_inc >= cfg_i.lost_limit);

  // Offset of the chosen midpoint from the centre
  assign diff    = {1'b0, dec_i.best_mid} - {1'b0, geom_i.centre};
  assign neg     = diff[pss_pkg::COL_W];
  assign mag     = neg ? pss_pkg::COL_W'(-diff) : diff[pss_pkg::COL_W-1:0];
  assign turn    = (mag > cfg_i.turn_margin);
  assign fwd     = (mag < cfg_i.forward_margin) | ~turn;
  assign rot_act = neg ? pss_pkg::ACT_LEFT : pss_pkg::ACT_RIGHT;
  assign opp_act = neg ? pss_pkg::ACT_RIGHT : pss_pkg::ACT_LEFT;

  // Build the one or two results of the frame
  always_comb begin
    r1.action  = pss_pkg::ACT_FWD;
    r1.amount  = {1'b0, cfg_i.move_speed};
    r1.give_up = 1'b0;
    r1.last    = 1'b1;
    two        = 1'b0;
    if (dec_i.lost) begin
      r0.action  = pss_pkg::ACT_FWD;
      r0.amount  = {cfg_i.move_speed, 1'b0};
      r0.give_up = give_up;
      r0.last    = 1'b1;
    end else if (turn) begin
      r0.action  = rot_act;
      r0.amount  = (prev_action_q == opp_act) ? cfg_i.small_turn : cfg_i.half_turn;
      r0.give_up = 1'b0;
      r0.last    = ~fwd;
      two        = fwd;
    end else begin
      r0 = r1;
    end
  end

  assign n_res   = two ? 2'd2 : 2'd1;
  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i & ~empty_o;
  assign res_o   = mem_q[rd_ptr_q];

  // Update steering history and result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      count_q       <= '0;
      lost_count_q  <= '0;
      prev_action_q <= pss_pkg::ACT_FWD;
    end else begin
      if (take) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
        if (dec_i.lost) begin
          lost_count_q <= give_up ? 8'd0 : lc_inc;
        end else begin
          lost_count_q  <= 8'd0;
          prev_action_q <= r0.action;
        end
      end
      if (do_pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + (take ? CntW'(n_res) : CntW'(0)) - CntW'(do_pop);
    end
  end

  // Store result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      mem_q[wr_ptr_q] <= r0;
      if (two) mem_q[wr_ptr_q + PtrW'(1)] <= r1;
    end
  end

endmodule

### hw/rtl/path_scanline_steering.sv
// Channel   Direction  Handshake              Payload
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
// pixels    in         push / full            in_item_i (pss_pkg::in_item_t)
// results   out        pop / empty            res_o (pss_pkg::res_item_t)
//
// One pixel is taken every clock while full is low; a frame decision is formed combinationally.
// The decision of a frame is registered in the decision queue; the steering stage then
// writes its results to the result queue, and the first shows on res_o to be popped.
// full rises only when two frame decisions wait for the steering stage; that stage
// holds while its four-entry result queue has fewer than two free slots.
// Reset is asynchronous and clears all control and configuration state at once, but not the queue storage.
`include "assert_macros.svh"

module path_scanline_steering (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  pss_pkg::in_item_t                     in_item_i,
  output logic                                  empty,
  input  logic                                  pop,
  output pss_pkg::res_item_t                    res_o
);

  pss_pkg::cfg_t  cfg_q;
  pss_pkg::geom_t geom;
  logic [10:0]    eff_w;

  logic          dec_push, dec_full, dec_empty, dec_pop;
  pss_pkg::dec_t dec_in, dec_out;

  logic          res_gu, res_gu_ok, res_mid, res_rot, dec_ok;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= 11'd320;
      cfg_q.min_area       <= 20'd1000;
      cfg_q.lost_limit     <= 8'd5;
      cfg_q.move_speed     <= 14'd10;
      cfg_q.half_turn      <= 15'd15;
      cfg_q.small_turn     <= 15'd1;
      cfg_q.turn_margin    <= 10'd20;
      cfg_q.forward_margin <= 10'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pss_pkg::CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data_i[10:0];
        pss_pkg::CFG_MIN_AREA:       cfg_q.min_area       <= cfg_data_i[19:0];
        pss_pkg::CFG_LOST_LIMIT:     cfg_q.lost_limit     <= cfg_data_i[7:0];
        pss_pkg::CFG_MOVE_SPEED:     cfg_q.move_speed     <= cfg_data_i[13:0];
        pss_pkg::CFG_HALF_TURN:      cfg_q.half_turn      <= cfg_data_i[14:0];
        pss_pkg::CFG_SMALL_TURN:     cfg_q.small_turn     <= cfg_data_i[14:0];
        pss_pkg::CFG_TURN_MARGIN:    cfg_q.turn_margin    <= cfg_data_i[9:0];
        pss_pkg::CFG_FORWARD_MARGIN: cfg_q.forward_margin <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Clamp the row width and derive last column and centre
  always_comb begin
    priority if (cfg_q.image_width < pss_pkg::MIN_WIDTH) eff_w = pss_pkg::MIN_WIDTH;
    else if (cfg_q.image_width > pss_pkg::MAX_WIDTH)     eff_w = pss_pkg::MAX_WIDTH;
    else                                                 eff_w = cfg_q.image_width;
  end

  assign geom.last_col = pss_pkg::COL_W'(eff_w - 11'd1);
  assign geom.centre   = eff_w[pss_pkg::COL_W:1];

  pss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .geom_i     (geom),
    .push_i     (push),
    .item_i     (in_item_i),
    .dq_full_i  (dec_full),
    .full_o     (full),
    .dec_push_o (dec_push),
    .dec_o      (dec_in)
  );

  pss_dec_fifo u_dec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dec_push),
    .data_i  (dec_in),
    .full_o  (dec_full),
    .pop_i   (dec_pop),
    .empty_o (dec_empty),
    .data_o  (dec_out)
  );

  pss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .geom_i      (geom),
    .dec_empty_i (dec_empty),
    .dec_i       (dec_out),
    .dec_pop_o   (dec_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

  // Checks
  assign res_gu    = !empty && res_o.give_up;
  assign res_gu_ok = (res_o.action == pss_pkg::ACT_FWD) && res_o.last;
  assign res_mid   = !empty && !res_o.last;
  assign res_rot   = (res_o.action == pss_pkg::ACT_LEFT) ||
                     (res_o.action == pss_pkg::ACT_RIGHT);
  assign dec_ok    = push && !full && in_item_i.row_sel;

  `ASSERT_IMPL(a_give_up_final_fwd, clk_i, rst_ni, res_gu, res_gu_ok, "give_up off a final forward")
  `ASSERT_IMPL(a_nonlast_is_rotation, clk_i, rst_ni, res_mid, res_rot, "non-final not a rotation")
  `ASSERT_IMPL(a_dec_from_lower_row, clk_i, rst_ni, dec_push, dec_ok, "decision without lower pixel")
  `ASSERT_NEXT(a_dec_queued, clk_i, rst_ni, dec_push, !dec_empty, "decision lost before steering")

endmodule
